[rtl/fixed_partition_fit_allocator_top_assert.svh]
// ============================================================================
// Assertion macros for the fixed partition fit allocator
// Shared concurrent assertion forms used by the allocator RTL.
// ============================================================================
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define FPFA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FPFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fpfa_pkg.sv]
// ============================================================================
// Fixed partition fit allocator package
// Shared types, codes and defaults for the allocator blocks.
// ============================================================================
package fpfa_pkg;

   localparam int DEF_MAX_PARTITIONS = 16;
   localparam int DEF_SIZE_BITS      = 16;

   localparam int KIND_W      = 2;
   localparam int SLOT_W      = 4;
   localparam int SIZE_KB_W   = 16;
   localparam int POLICY_W    = 2;
   localparam int CFG_PARTS_W = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CFG_PARTS_W-1:0] RESET_PARTS_IN_USE = 5'd16;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_REQUEST = 2'd1,
      KIND_RESTART = 2'd2
   } kind_type;

   typedef enum logic [POLICY_W-1:0] {
      POLICY_FIRST = 2'd0,
      POLICY_BEST  = 2'd1,
      POLICY_WORST = 2'd2,
      POLICY_NEXT  = 2'd3
   } fit_policy_type;

   typedef enum logic [0:0] {
      REG_FIT_POLICY    = 1'b0,
      REG_PARTS_IN_USE  = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_REQUEST,
      OP_RESTART
   } op_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [SLOT_W-1:0]    slot;
      logic [SIZE_KB_W-1:0] size_kb;
   } req_type;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] chosen_slot;
   } rsp_type;

   typedef struct packed {
      op_type               op;
      logic [SLOT_W-1:0]    slot;
      logic [SIZE_KB_W-1:0] size_kb;
   } cmd_type;

endpackage

[rtl/fpfa_ram.sv]
// ============================================================================
// Generic RAM
// One write port, one read port, registered read data.
// ============================================================================
module fpfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/fpfa_front.sv]
// ============================================================================
// Allocator front end
// Accepts input beats, classifies them and queues commands for the back end.
// ============================================================================
module fpfa_front import fpfa_pkg::*; #(
   parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_pop
);

   localparam int QDEPTH = 2;

   cmd_type    q_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   logic    accept;
   logic    keep;
   logic    push;
   cmd_type cmd_new;

   assign req_stall = (count_ff == 2'(QDEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      keep            = 1'b0;
      cmd_new.op      = OP_LOAD;
      cmd_new.slot    = req_data.slot;
      cmd_new.size_kb = req_data.size_kb;
      unique case (req_data.kind)
         KIND_LOAD: begin
            cmd_new.op = OP_LOAD;
            keep       = (32'(req_data.slot) < MAX_PARTITIONS);
         end
         KIND_REQUEST: begin
            cmd_new.op = OP_REQUEST;
            keep       = 1'b1;
         end
         KIND_RESTART: begin
            cmd_new.op = OP_RESTART;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push      = accept && keep;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, cmd_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

[rtl/fpfa_back.sv]
// ============================================================================
// Allocator back end
// Executes load, restart and request commands; scans one partition a cycle.
// ============================================================================
`include "fixed_partition_fit_allocator_top_assert.svh"

module fpfa_back import fpfa_pkg::*; #(
   parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
   parameter int SIZE_BITS      = DEF_SIZE_BITS,
   localparam int IDX_W = $clog2(MAX_PARTITIONS),
   localparam int CNT_W = $clog2(MAX_PARTITIONS + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           cmd_valid,
   input  cmd_type        cmd_data,
   output logic           cmd_pop,
   input  fit_policy_type fit_policy,
   input  logic [CNT_W-1:0] part_count,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data
);

   localparam int CMP_W = (SIZE_BITS > SIZE_KB_W) ? SIZE_BITS : SIZE_KB_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [MAX_PARTITIONS-1:0] taken_ff, taken_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic [CNT_W-1:0]          left_ff, left_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]          cmp_pos_ff, cmp_pos_in;
   logic                      found_ff, found_in;
   logic [IDX_W-1:0]          pick_ff, pick_in;
   logic [SIZE_BITS-1:0]      pick_size_ff, pick_size_in;
   logic [SIZE_KB_W-1:0]      want_ff, want_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [SIZE_BITS-1:0] ram_wdata;
   logic                 ram_re;
   logic [SIZE_BITS-1:0] ram_rdata;

   logic             out_free;
   logic [IDX_W-1:0] pos_next;
   logic [IDX_W-1:0] pick_wrap;
   logic             fit;
   logic             better;

   fpfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_PARTITIONS)
   ) u_size_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_en      (ram_re),
      .rd_addr    (pos_ff),
      .rd_data_ff (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pos_next  = ((CNT_W'(pos_ff) + CNT_W'(1)) == part_count) ? '0
                                                                   : pos_ff + IDX_W'(1);
   assign pick_wrap = ((CNT_W'(pick_ff) + CNT_W'(1)) == part_count) ? '0
                                                                    : pick_ff + IDX_W'(1);
   assign fit       = !taken_ff[cmp_pos_ff] && (CMP_W'(ram_rdata) >= CMP_W'(want_ff));
   assign better    = !found_ff
                   || (fit_policy == POLICY_BEST  && ram_rdata < pick_size_ff)
                   || (fit_policy == POLICY_WORST && ram_rdata > pick_size_ff);

   assign ram_waddr = IDX_W'(cmd_data.slot);
   assign ram_wdata = SIZE_BITS'(cmd_data.size_kb);

   always_comb begin
      state_in     = state_ff;
      taken_in     = taken_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_pos_in   = cmp_pos_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_size_in = pick_size_ff;
      want_in      = want_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd_data.op)
                  OP_LOAD: begin
                     ram_we              = 1'b1;
                     taken_in[ram_waddr] = 1'b0;
                  end
                  OP_RESTART: begin
                     taken_in = '0;
                     ptr_in   = '0;
                  end
                  OP_REQUEST: begin
                     want_in    = cmd_data.size_kb;
                     found_in   = 1'b0;
                     pick_in    = '0;
                     cmp_vld_in = 1'b0;
                     left_in    = part_count;
                     pos_in     = (fit_policy == POLICY_NEXT
                                   && CNT_W'(ptr_ff) < part_count) ? ptr_ff : '0;
                     state_in   = (part_count == '0) ? ST_DONE : ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (left_ff != '0) begin
               ram_re     = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_pos_in = pos_ff;
               left_in    = left_ff - CNT_W'(1);
               pos_in     = pos_next;
            end else begin
               cmp_vld_in = 1'b0;
            end
            if (cmp_vld_ff && fit && better) begin
               found_in     = 1'b1;
               pick_in      = cmp_pos_ff;
               pick_size_in = ram_rdata;
            end
            if (left_ff == '0 && !cmp_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.granted     = found_ff;
               rsp_data_in.chosen_slot = found_ff ? SLOT_W'(pick_ff) : '0;
               if (found_ff) begin
                  taken_in[pick_ff] = 1'b1;
                  if (fit_policy == POLICY_NEXT) begin
                     ptr_in = pick_wrap;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         taken_ff     <= '0;
         ptr_ff       <= '0;
         left_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taken_ff     <= taken_in;
         ptr_ff       <= ptr_in;
         left_ff      <= left_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      cmp_pos_ff   <= cmp_pos_in;
      found_ff     <= found_in;
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
      want_ff      <= want_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FPFA_ASSERT_NEXT(a_grant_marks_taken, clock, reset, (state_ff == ST_DONE && out_free && found_ff), taken_ff[$past(pick_ff)], "granted partition not marked taken")
   `FPFA_ASSERT_IMPLY(a_idle_scan_quiet, clock, reset, state_ff == ST_IDLE, !cmp_vld_ff && left_ff == '0, "scan activity outside scan state")
   `FPFA_ASSERT_IMPLY(a_pick_in_range, clock, reset, (state_ff != ST_IDLE && found_ff), CNT_W'(pick_ff) < part_count, "pick outside partitions in use")

endmodule

[rtl/fixed_partition_fit_allocator_top.sv]
// ============================================================================
// Fixed partition fit allocator
// Allocates fixed memory partitions by first, best, worst or next fit.
// ============================================================================
// Usage:
//   req channel (req_valid/req_stall/req_data) takes load, request and
//   restart beats. Only a request beat produces a beat on the rsp channel
//   (granted, chosen_slot); loads and restarts give no result beat.
//   A two-entry command queue sits between the front end and the back end,
//   so input beats keep landing while the back end scans or waits.
//   Load and restart complete as the command is popped from the queue. A
//   request holds the back end through the queue pop, one registered size
//   read per partition in use, draining the compare and posting the result.
//   A stalled rsp beat holds; the back end then waits with the next result
//   while the queue can still take input beats until full.
//   Configure through the csr port only while idle: fit_policy at byte 0,
//   partitions_in_use at byte 4.
//   Reset clears all taken marks, the next-fit pointer and the queue and sets
//   fit_policy to first fit and partitions_in_use to 16. Partition sizes are
//   undefined until loaded.
// ============================================================================
module fixed_partition_fit_allocator_top import fpfa_pkg::*; #(
   parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
   parameter int SIZE_BITS      = DEF_SIZE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

   fit_policy_type         policy_ff, policy_in;
   logic [CFG_PARTS_W-1:0] parts_ff, parts_in;
   logic                   csr_wr;
   reg_index_type          csr_index;
   logic [CNT_W-1:0]       part_count;

   logic    cmd_valid;
   cmd_type cmd_data;
   logic    cmd_pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      policy_in = policy_ff;
      parts_in  = parts_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_FIT_POLICY:   policy_in = fit_policy_type'(csr_pwdata[POLICY_W-1:0]);
            REG_PARTS_IN_USE: parts_in  = csr_pwdata[CFG_PARTS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FIT_POLICY:   csr_prdata = CSR_DATA_W'(policy_ff);
         REG_PARTS_IN_USE: csr_prdata = CSR_DATA_W'(parts_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIRST;
         parts_ff  <= RESET_PARTS_IN_USE;
      end else begin
         policy_ff <= policy_in;
         parts_ff  <= parts_in;
      end
   end

   assign part_count = (32'(parts_ff) > MAX_PARTITIONS) ? CNT_W'(MAX_PARTITIONS)
                                                         : CNT_W'(parts_ff);

   fpfa_front #(
      .MAX_PARTITIONS (MAX_PARTITIONS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   fpfa_back #(
      .MAX_PARTITIONS (MAX_PARTITIONS),
      .SIZE_BITS      (SIZE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_data   (cmd_data),
      .cmd_pop    (cmd_pop),
      .fit_policy (policy_ff),
      .part_count (part_count),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[tb/sv/tb_fixed_partition_fit_allocator_top.sv]
// ============================================================================
// Fixed partition fit allocator testbench
// Loads a partition table, then runs directed and random load, request and
// restart beats under all four fit policies and several in-use counts. Every
// request result is checked against its typed row or an in-bench allocator,
// with random idle gaps on both channels and one long result hold-off.
// ============================================================================
module tb_fixed_partition_fit_allocator_top import fpfa_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int DIRECTED_ROWS   = 25;
   localparam int SETTLE_CYCLES   = 60;
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 300000;
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;
   localparam bit GRANT     = 1'b1;
   localparam bit REFUSE    = 1'b0;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // allocator state as seen by the checker
   logic [SIZE_KB_W-1:0] part_size  [DEF_MAX_PARTITIONS];
   bit                   part_taken [DEF_MAX_PARTITIONS];
   int                   next_fit_ptr;
   fit_policy_type       policy_now;
   logic [CFG_PARTS_W-1:0] parts_now;

   rsp_type expected_grants [$];
   rsp_type grant_want;
   int      mismatches;
   int      cycle_count;
   bit      steady;
   bit      pressure_phase;
   bit      hold_rsp;
   dir_row_type directed_rows [DIRECTED_ROWS];

   fixed_partition_fit_allocator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int find_partition(input logic [SIZE_KB_W-1:0] want);
      int n;
      int pick;
      int pos;
      n = (parts_now > DEF_MAX_PARTITIONS) ? DEF_MAX_PARTITIONS : int'(parts_now);
      pick = -1;
      if (n == 0) return -1;
      if (policy_now == POLICY_NEXT) begin
         pos = (next_fit_ptr < n) ? next_fit_ptr : 0;
         for (int j = 0; j < n; j++) begin
            if (!part_taken[pos] && part_size[pos] >= want) begin
               next_fit_ptr = (pos + 1) % n;
               return pos;
            end
            pos = (pos + 1) % n;
         end
         return -1;
      end
      for (int j = 0; j < n; j++) begin
         if (part_taken[j] || part_size[j] < want) continue;
         if (policy_now == POLICY_FIRST) return j;
         if (pick < 0 ||
             (policy_now == POLICY_BEST  && part_size[j] < part_size[pick]) ||
             (policy_now == POLICY_WORST && part_size[j] > part_size[pick]))
            pick = j;
      end
      return pick;
   endfunction

   function automatic void predict_allocation(input req_type beat, output bit has_rsp,
                                              output rsp_type grant);
      int pick;
      has_rsp = 1'b0;
      grant   = '0;
      case (beat.kind)
         KIND_LOAD: begin
            part_size[beat.slot]  = beat.size_kb;
            part_taken[beat.slot] = 1'b0;
         end
         KIND_RESTART: begin
            foreach (part_taken[k]) part_taken[k] = 1'b0;
            next_fit_ptr = 0;
         end
         KIND_REQUEST: begin
            has_rsp = 1'b1;
            pick = find_partition(beat.size_kb);
            if (pick >= 0) begin
               part_taken[pick]  = 1'b1;
               grant.granted     = 1'b1;
               grant.chosen_slot = pick[SLOT_W-1:0];
            end
         end
         default: ;
      endcase
   endfunction

   function automatic dir_row_type stim_row(input logic [KIND_W-1:0] kind,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [SIZE_KB_W-1:0] size_kb,
                                            input bit typed, input bit granted,
                                            input logic [SLOT_W-1:0] chosen);
      dir_row_type row;
      row.beat.kind         = kind;
      row.beat.slot         = slot;
      row.beat.size_kb      = size_kb;
      row.typed             = typed;
      row.want.granted      = granted;
      row.want.chosen_slot  = chosen;
      return row;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type random_beat();
      req_type b;
      int r;
      int ref_slot;
      r = $urandom_range(0, 99);
      b.slot    = SLOT_W'($urandom_range(0, 15));
      b.size_kb = SIZE_KB_W'($urandom);
      if (r < 25) begin
         b.kind = KIND_LOAD;
         if ($urandom_range(0, 3) != 0)
            b.size_kb = SIZE_KB_W'($urandom_range(0, 15) * 256);
      end else if (r < 33) begin
         b.kind = KIND_RESTART;
      end else if (r < 36) begin
         b.kind = KIND_UNUSED;
      end else begin
         b.kind = KIND_REQUEST;
         r = $urandom_range(0, 99);
         ref_slot = $urandom_range(0, DEF_MAX_PARTITIONS - 1);
         if (r < 50)
            b.size_kb = part_size[ref_slot];
         else if (r < 80)
            b.size_kb = SIZE_KB_W'($urandom_range(0, 4096));
      end
      return b;
   endfunction

   task automatic send_beat(input req_type beat, input bit typed, input rsp_type want);
      bit      has_rsp;
      rsp_type pred;
      int      gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predict_allocation(beat, has_rsp, pred);
      if (has_rsp) expected_grants.push_back(typed ? want : pred);
      gap = (steady || pressure_phase) ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read_check(input reg_index_type idx, input logic [CSR_DATA_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         $error("csr %s: expected %0d, got %0d", idx.name(), want, got);
         mismatches++;
      end
   endtask

   task automatic set_register(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_FIT_POLICY) policy_now = fit_policy_type'(value[POLICY_W-1:0]);
      else                       parts_now  = value[CFG_PARTS_W-1:0];
      csr_read_check(idx, value);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_grants.size() == 0) begin
            $error("result beat with nothing expected: granted %0d slot %0d",
                   rsp_data.granted, rsp_data.chosen_slot);
            mismatches++;
         end else begin
            grant_want = expected_grants.pop_front();
            if (rsp_data.granted !== grant_want.granted) begin
               $error("granted: expected %0d, got %0d", grant_want.granted, rsp_data.granted);
               mismatches++;
            end
            if (rsp_data.chosen_slot !== grant_want.chosen_slot) begin
               $error("chosen_slot: expected %0d, got %0d",
                      grant_want.chosen_slot, rsp_data.chosen_slot);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result-side stall
   initial begin
      int r;
      int len;
      bit stall_bit;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               stall_bit = 1'b0;
               len = $urandom_range(1, 6);
            end else if (r < 90) begin
               stall_bit = 1'b1;
               len = $urandom_range(1, 3);
            end else begin
               stall_bit = 1'b1;
               len = $urandom_range(10, 40);
            end
            rsp_stall <= stall_bit;
            repeat (len - 1) @(negedge clock);
         end
      end
   end

   initial begin
      int             count;
      req_type        beat;
      fit_policy_type pol;
      logic [CFG_PARTS_W-1:0] parts;
      fit_policy_type phase_policy [7];
      logic [CFG_PARTS_W-1:0] phase_parts [7];

      phase_policy = '{POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_NEXT,
                       POLICY_NEXT, POLICY_NEXT, POLICY_BEST};
      phase_parts  = '{5'd16, 5'd1, 5'd31, 5'd16, 5'd5, 5'd0, 5'd16};

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatches     = 0;
      cycle_count    = 0;
      steady         = 1'b0;
      pressure_phase = 1'b0;
      hold_rsp       = 1'b0;
      foreach (part_size[k]) begin
         part_size[k]  = '0;
         part_taken[k] = 1'b0;
      end
      next_fit_ptr = 0;
      policy_now   = POLICY_FIRST;
      parts_now    = RESET_PARTS_IN_USE;

      directed_rows = '{
         stim_row(KIND_LOAD,     4'd0,  16'h0000, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd1,  16'h0800, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd2,  16'h0400, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd3,  16'h0400, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd4,  16'h1000, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd5,  16'h0200, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd6,  16'h7FFF, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd7,  16'h8000, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd8,  16'h0001, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd9,  16'h0C00, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd10, 16'h0400, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd11, 16'h2000, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd12, 16'h00FF, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd13, 16'h5555, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd14, 16'hAAAA, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_LOAD,     4'd15, 16'hFFFF, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_REQUEST,  4'd0,  16'h0000, TYPED,     GRANT,  4'd0),
         stim_row(KIND_REQUEST,  4'd0,  16'hFFFF, TYPED,     GRANT,  4'd15),
         stim_row(KIND_REQUEST,  4'd15, 16'hFFFF, TYPED,     REFUSE, 4'd0),
         stim_row(KIND_UNUSED,   4'd15, 16'hFFFF, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_REQUEST,  4'd0,  16'h0401, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_RESTART,  4'd0,  16'h0000, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_REQUEST,  4'd0,  16'hFFFF, TYPED,     GRANT,  4'd15),
         stim_row(KIND_LOAD,     4'd15, 16'h0000, PREDICTED, REFUSE, 4'd0),
         stim_row(KIND_REQUEST,  4'd0,  16'h8001, PREDICTED, REFUSE, 4'd0)
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read_check(REG_FIT_POLICY, CSR_DATA_W'(POLICY_FIRST));
      csr_read_check(REG_PARTS_IN_USE, CSR_DATA_W'(RESET_PARTS_IN_USE));

      // whole table is loaded before the first request reads it
      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle_block();
         if (p < 7) begin
            pol   = phase_policy[p];
            parts = phase_parts[p];
         end else begin
            pol   = fit_policy_type'($urandom_range(0, 3));
            parts = CFG_PARTS_W'($urandom_range(0, 31));
         end
         set_register(REG_FIT_POLICY, CSR_DATA_W'(pol));
         set_register(REG_PARTS_IN_USE, CSR_DATA_W'(parts));
         steady         = (p == 5) || (p >= 7 && $urandom_range(0, 3) == 0);
         pressure_phase = (p == 2);
         if (pressure_phase) hold_rsp = 1'b1;
         count = 0;
         while (count < ITEMS_PER_PHASE) begin
            beat = random_beat();
            send_beat(beat, PREDICTED, '0);
            if (beat.kind != KIND_UNUSED) count++;
         end
         steady         = 1'b0;
         pressure_phase = 1'b0;
      end
      settle_block();

      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else                 $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/fpfa_pkg.sv
rtl/fpfa_ram.sv
rtl/fpfa_front.sv
rtl/fpfa_back.sv
rtl/fixed_partition_fit_allocator_top.sv
tb/sv/tb_fixed_partition_fit_allocator_top.sv
